// ===== hdl/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1_pkg
// Types and constants shared by the SHA-1 digest controller, datapath and top.
// ----------------------------------------------------------------------------
package sha1_pkg;

	localparam logic        KIND_DATA   = 1'b0;
	localparam logic        KIND_FINISH = 1'b1;

	localparam logic [5:0]  POS_LAST    = 6'd63;
	localparam logic [5:0]  POS_LEN     = 6'd56;
	localparam logic [6:0]  ROUND_LAST  = 7'd79;
	localparam logic [6:0]  ROUND_G1    = 7'd20;
	localparam logic [6:0]  ROUND_G2    = 7'd40;
	localparam logic [6:0]  ROUND_G3    = 7'd60;
	localparam logic [2:0]  WORD_LAST   = 3'd4;
	localparam logic [7:0]  PAD_BYTE    = 8'h80;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [31:0] H0_INIT = 32'h67452301;
	localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
	localparam logic [31:0] H2_INIT = 32'h98BADCFE;
	localparam logic [31:0] H3_INIT = 32'h10325476;
	localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

	typedef enum logic [1:0] {
		SEL_DATA = 2'd0,
		SEL_PAD  = 2'd1,
		SEL_ZERO = 2'd2,
		SEL_LEN  = 2'd3
	} byte_sel_t;

	typedef struct packed {
		logic       absorb;
		byte_sel_t  sel;
		logic       load_len;
		logic       start_comp;
		logic       round_en;
		logic [6:0] round;
		logic       fold;
		logic       restart;
		logic [2:0] out_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0] pos;
	} dp_stat_t;

endpackage

// ===== hdl/sha1_if.sv =====
// ----------------------------------------------------------------------------
// sha1 channel interfaces
// Valid/ready channels for message items and digest word items.
// ----------------------------------------------------------------------------
interface sha1_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface sha1_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index, output last_word,
		input ready);
	modport sink   (input valid, input digest_word, input word_index, input last_word,
		output ready);
endinterface

// ===== hdl/sha1_message_digest.sv =====
// ----------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 digest of a byte stream; a finish item pads and emits five words.
// ----------------------------------------------------------------------------
// Message bytes are taken one per cycle while the 64-byte block fills. The
// byte that completes a block starts a busy compression: 80 rounds on the
// single round unit, one per cycle, then a fold of the result into the
// chaining words. A finish item feeds the padding and length bytes through the
// same path at one per cycle, pausing once at the length boundary, runs one
// or two compressions, then presents digest words 0 to 4 one at a time; the
// next message may start in the cycle after word 4 is taken.
module sha1_message_digest (
	input  logic clk,
	input  logic arst_n,
	sha1_in_if.sink    msg,
	sha1_out_if.source dig
);
	import sha1_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	sha1_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg.valid),
		.msg_kind  (msg.kind),
		.msg_ready (msg.ready),
		.dig_valid (dig.valid),
		.dig_ready (dig.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sha1_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (msg.data_byte),
		.cmd         (cmd),
		.stat        (stat),
		.digest_word (dig.digest_word)
	);

	assign dig.word_index = cmd.out_idx;
	assign dig.last_word  = (cmd.out_idx == WORD_LAST);

`ifndef NO_ASSERTIONS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(msg.ready && dig.valid))
		else $error("input taken while digest pending");

	a_ready_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(dig.valid && dig.ready && dig.last_word) |=> msg.ready)
		else $error("not ready after last digest word");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		(dig.valid && dig.ready && !dig.last_word) |=>
		(dig.valid && dig.word_index == $past(dig.word_index) + 3'd1))
		else $error("digest word index did not advance");

	a_idle_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(msg.valid && msg.ready && msg.kind) |=> !msg.ready)
		else $error("ready during padding");
`endif

endmodule

// ===== hdl/sha1_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha1_ctrl
// Sequencer: byte intake, padding, round stepping, fold and digest output.
// ----------------------------------------------------------------------------
module sha1_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              msg_valid,
	input  logic              msg_kind,
	output logic              msg_ready,
	output logic              dig_valid,
	input  logic              dig_ready,
	input  sha1_pkg::dp_stat_t stat,
	output sha1_pkg::dp_cmd_t  cmd
);
	import sha1_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_PAD80  = 7'b0000010,
		ST_PADZ   = 7'b0000100,
		ST_PADLEN = 7'b0001000,
		ST_COMP   = 7'b0010000,
		ST_FOLD   = 7'b0100000,
		ST_EMIT   = 7'b1000000
	} state_t;

	state_t     state_q, state_d, ret_q, ret_d;
	logic [6:0] rnd_q;
	logic [2:0] idx_q;

	always_comb begin
		state_d   = state_q;
		ret_d     = ret_q;
		cmd       = '0;
		cmd.sel   = SEL_DATA;
		cmd.round = rnd_q;
		cmd.out_idx = idx_q;
		msg_ready = 1'b0;
		dig_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				msg_ready = 1'b1;
				if (msg_valid) begin
					if (msg_kind == KIND_FINISH) begin
						cmd.load_len = 1'b1;
						state_d      = ST_PAD80;
					end else begin
						cmd.absorb = 1'b1;
						if (stat.pos == POS_LAST) begin
							cmd.start_comp = 1'b1;
							ret_d          = ST_IDLE;
							state_d        = ST_COMP;
						end
					end
				end
			end
			ST_PAD80: begin
				cmd.absorb = 1'b1;
				cmd.sel    = SEL_PAD;
				state_d    = ST_PADZ;
				if (stat.pos == POS_LAST) begin
					cmd.start_comp = 1'b1;
					ret_d          = ST_PADZ;
					state_d        = ST_COMP;
				end
			end
			ST_PADZ: begin
				if (stat.pos == POS_LEN) begin
					state_d = ST_PADLEN;
				end else begin
					cmd.absorb = 1'b1;
					cmd.sel    = SEL_ZERO;
					if (stat.pos == POS_LAST) begin
						cmd.start_comp = 1'b1;
						ret_d          = ST_PADZ;
						state_d        = ST_COMP;
					end
				end
			end
			ST_PADLEN: begin
				cmd.absorb = 1'b1;
				cmd.sel    = SEL_LEN;
				if (stat.pos == POS_LAST) begin
					cmd.start_comp = 1'b1;
					ret_d          = ST_EMIT;
					state_d        = ST_COMP;
				end
			end
			ST_COMP: begin
				cmd.round_en = 1'b1;
				if (rnd_q == ROUND_LAST) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				state_d  = ret_q;
			end
			ST_EMIT: begin
				dig_valid = 1'b1;
				if (dig_ready && idx_q == WORD_LAST) begin
					cmd.restart = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			rnd_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (cmd.start_comp) begin
				rnd_q <= '0;
			end else if (cmd.round_en) begin
				rnd_q <= rnd_q + 7'd1;
			end
			if (cmd.restart) begin
				idx_q <= '0;
			end else if (dig_valid && dig_ready) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

endmodule

// ===== hdl/sha1_dp.sv =====
// ----------------------------------------------------------------------------
// sha1_dp
// Datapath: block shift register, bit count, round unit and chaining words.
// ----------------------------------------------------------------------------
module sha1_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        data_byte,
	input  sha1_pkg::dp_cmd_t  cmd,
	output sha1_pkg::dp_stat_t stat,
	output logic [31:0]       digest_word
);
	import sha1_pkg::*;

	logic [31:0] w_q [0:15];
	logic [31:0] h_q [0:4];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [63:0] cnt_q;
	logic [63:0] len_q;
	logic [7:0]  byte_in;
	logic [31:0] f_val, k_val, t_val, w_new;

	always_comb begin
		case (cmd.sel)
			SEL_DATA: byte_in = data_byte;
			SEL_PAD:  byte_in = PAD_BYTE;
			SEL_ZERO: byte_in = 8'h00;
			SEL_LEN:  byte_in = len_q[63:56];
			default:  byte_in = 8'h00;
		endcase
	end

	always_comb begin
		if (cmd.round < ROUND_G1) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = K0;
		end else if (cmd.round < ROUND_G2) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K1;
		end else if (cmd.round < ROUND_G3) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = K2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K3;
		end
	end

	logic [31:0] w_x;
	assign w_x   = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign w_new = {w_x[30:0], w_x[31]};
	assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + w_q[0];

	assign stat.pos = cnt_q[8:3];

	always_comb begin
		case (cmd.out_idx)
			3'd0:    digest_word = h_q[0];
			3'd1:    digest_word = h_q[1];
			3'd2:    digest_word = h_q[2];
			3'd3:    digest_word = h_q[3];
			3'd4:    digest_word = h_q[4];
			default: digest_word = h_q[0];
		endcase
	end

	// block words, round variables and message length register
	always_ff @(posedge clk) begin
		if (cmd.absorb) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
			end
			w_q[15] <= {w_q[15][23:0], byte_in};
		end else if (cmd.round_en) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
		end
		if (cmd.start_comp) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (cmd.round_en) begin
			a_q <= t_val;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
		if (cmd.load_len) begin
			len_q <= cnt_q;
		end else if (cmd.absorb && cmd.sel == SEL_LEN) begin
			len_q <= {len_q[55:0], 8'h00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q[0] <= H0_INIT;
			h_q[1] <= H1_INIT;
			h_q[2] <= H2_INIT;
			h_q[3] <= H3_INIT;
			h_q[4] <= H4_INIT;
			cnt_q  <= '0;
		end else begin
			if (cmd.restart) begin
				h_q[0] <= H0_INIT;
				h_q[1] <= H1_INIT;
				h_q[2] <= H2_INIT;
				h_q[3] <= H3_INIT;
				h_q[4] <= H4_INIT;
			end else if (cmd.fold) begin
				h_q[0] <= h_q[0] + a_q;
				h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q;
			end
			if (cmd.restart) begin
				cnt_q <= '0;
			end else if (cmd.absorb) begin
				cnt_q <= {cnt_q[63:3] + 61'd1, cnt_q[2:0]};
			end
		end
	end

endmodule
